@@ sv/deq_pkg.sv @@
// Shared constants for the double-ended queue: field widths, opcodes and status codes.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ_BACK  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_READ_INDEX = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

@@ sv/deq_if.sv @@
// Request and response channel interfaces of the double-ended queue.
`timescale 1ns / 1ps

interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::OPCODE_W-1:0]  opcode;
  logic [deq_pkg::VALUE_W-1:0]   value;
  logic [deq_pkg::POS_W-1:0]     position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

interface deq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::VALUE_W-1:0]   read_data;
  logic [deq_pkg::COUNT_W-1:0]   count;
  logic [deq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output read_data, output count, output status, input ready);
  modport sink (input valid, input read_data, input count, input status, output ready);
endinterface

@@ sv/double_ended_queue.sv @@
// Top level of the double-ended queue: pointer logic, element memory and response stages.
// Circular-buffer deque of DEPTH elements of DATA_WIDTH bits, held in one single-port
// synchronous memory. Every request item (push/pop at either end, read front/back/index,
// clear) gives exactly one response item with read data, element count and status.
// Front pointer and count live in registers and are updated at the edge the request is
// accepted, so the block takes one item per cycle while the response side keeps up. The
// memory is read at the accepting edge into a read register; the response item passes a
// pending register and is then presented from an output register. A stalled response
// holds one more item behind it and then blocks the input. A full queue refuses pushes.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  deq_req_if.sink       req,
  deq_rsp_if.source     rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > deq_pkg::POS_W) ? CNT_W : deq_pkg::POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;

  logic [PTR_W-1:0] front, front_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  logic                          acc;
  logic                          full, empty;
  logic [PTR_W-1:0]              off, slot, front_dec, addr;
  logic [PTR_W:0]                sum;
  logic [deq_pkg::STATUS_W-1:0]  status;
  logic                          rd_ok, wr_ok;

  logic                          p_valid, p_rd, p_move;
  logic [deq_pkg::COUNT_W-1:0]   p_count;
  logic [deq_pkg::STATUS_W-1:0]  p_status;

  logic                          o_valid;
  logic [deq_pkg::VALUE_W-1:0]   o_data;
  logic [deq_pkg::COUNT_W-1:0]   o_count;
  logic [deq_pkg::STATUS_W-1:0]  o_status;

  assign acc   = req.valid && req.ready;
  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);

  always_comb begin
    case (req.opcode)
      deq_pkg::OP_PUSH_BACK:  off = cnt[PTR_W-1:0];
      deq_pkg::OP_READ_BACK:  off = PTR_W'(cnt - CNT_W'(1));
      deq_pkg::OP_READ_INDEX: off = PTR_W'(req.position);
      default:                off = '0;
    endcase
  end

  assign sum       = {1'b0, front} + {1'b0, off};
  assign slot      = (sum >= (PTR_W + 1)'(DEPTH)) ? PTR_W'(sum - (PTR_W + 1)'(DEPTH))
                                                  : sum[PTR_W-1:0];
  assign front_dec = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);

  always_comb begin
    front_next = front;
    cnt_next   = cnt;
    status     = deq_pkg::ST_OK;
    rd_ok      = 1'b0;
    wr_ok      = 1'b0;
    addr       = slot;
    unique case (req.opcode)
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          wr_ok    = 1'b1;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        addr = front_dec;
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          wr_ok      = 1'b1;
          front_next = front_dec;
          cnt_next   = cnt + CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) status = deq_pkg::ST_EMPTY;
        else cnt_next = cnt - CNT_W'(1);
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          front_next = (front == PTR_W'(DEPTH - 1)) ? '0 : front + PTR_W'(1);
          cnt_next   = cnt - CNT_W'(1);
        end
      end
      deq_pkg::OP_READ_FRONT, deq_pkg::OP_READ_BACK: begin
        if (empty) status = deq_pkg::ST_EMPTY;
        else rd_ok = 1'b1;
      end
      deq_pkg::OP_READ_INDEX: begin
        if (CMP_W'(req.position) >= CMP_W'(cnt)) status = deq_pkg::ST_RANGE;
        else rd_ok = 1'b1;
      end
      deq_pkg::OP_CLEAR: begin
        front_next = '0;
        cnt_next   = '0;
      end
      default: begin
        status = deq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && wr_ok) mem[addr] <= DATA_WIDTH'(req.value);
    if (acc && rd_ok) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
    end else if (acc) begin
      front <= front_next;
      cnt   <= cnt_next;
    end
  end

  assign p_move    = p_valid && (!o_valid || rsp.ready);
  assign req.ready = !p_valid || p_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (acc) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_rd     <= rd_ok;
      p_count  <= deq_pkg::COUNT_W'(cnt_next);
      p_status <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_move) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_data   <= p_rd ? deq_pkg::VALUE_W'(rdata) : '0;
      o_count  <= p_count;
      o_status <= p_status;
    end
  end

  assign rsp.valid     = o_valid;
  assign rsp.read_data = o_data;
  assign rsp.count     = o_count;
  assign rsp.status    = o_status;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH) && front <= PTR_W'(DEPTH - 1))
    else $error("count or front pointer out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    acc && wr_ok |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("accepted push did not grow the queue");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_move |=> p_valid && $stable(p_status) && $stable(p_count))
    else $error("stalled pending item changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_status != deq_pkg::ST_OK |-> o_data == '0)
    else $error("failed action returned nonzero data");

endmodule

@@ tb/double_ended_queue_checker.sv @@
// Checker for the double-ended queue: predicts each response item and compares it.
`timescale 1ns / 1ps

module double_ended_queue_checker (
  input  logic clk,
  input  logic rst,
  deq_req_if   req,
  deq_rsp_if   rsp,
  output int   failures,
  output int   outstanding
);

  localparam int SLOTS = 64;

  typedef struct packed {
    logic [deq_pkg::VALUE_W-1:0]  read_data;
    logic [deq_pkg::COUNT_W-1:0]  count;
    logic [deq_pkg::STATUS_W-1:0] status;
  } deq_result_t;

  logic [deq_pkg::VALUE_W-1:0] slots [SLOTS];
  logic [deq_pkg::POS_W-1:0]   head;
  logic [deq_pkg::COUNT_W-1:0] fill;
  deq_result_t                 awaited_results[$];

  // Slot arithmetic wraps for free: SLOTS is 2**POS_W.
  function automatic deq_result_t apply_request(input logic [deq_pkg::OPCODE_W-1:0] op,
                                                input logic [deq_pkg::VALUE_W-1:0]  val,
                                                input logic [deq_pkg::POS_W-1:0]    pos);
    deq_result_t r;
    r = '0;
    r.status = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (fill == deq_pkg::COUNT_W'(SLOTS)) r.status = deq_pkg::ST_FULL;
        else begin
          slots[head + fill[deq_pkg::POS_W-1:0]] = val;
          fill = fill + deq_pkg::COUNT_W'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (fill == deq_pkg::COUNT_W'(SLOTS)) r.status = deq_pkg::ST_FULL;
        else begin
          head = head - deq_pkg::POS_W'(1);
          slots[head] = val;
          fill = fill + deq_pkg::COUNT_W'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (fill == '0) r.status = deq_pkg::ST_EMPTY;
        else fill = fill - deq_pkg::COUNT_W'(1);
      end
      deq_pkg::OP_POP_FRONT: begin
        if (fill == '0) r.status = deq_pkg::ST_EMPTY;
        else begin
          head = head + deq_pkg::POS_W'(1);
          fill = fill - deq_pkg::COUNT_W'(1);
        end
      end
      deq_pkg::OP_READ_FRONT: begin
        if (fill == '0) r.status = deq_pkg::ST_EMPTY;
        else r.read_data = slots[head];
      end
      deq_pkg::OP_READ_BACK: begin
        if (fill == '0) r.status = deq_pkg::ST_EMPTY;
        else r.read_data = slots[deq_pkg::POS_W'(head + fill[deq_pkg::POS_W-1:0]
                                                  - deq_pkg::POS_W'(1))];
      end
      deq_pkg::OP_READ_INDEX: begin
        if ({1'b0, pos} >= fill) r.status = deq_pkg::ST_RANGE;
        else r.read_data = slots[deq_pkg::POS_W'(head + pos)];
      end
      default: begin
        fill = '0;
        head = '0;
      end
    endcase
    r.count = fill;
    return r;
  endfunction

  task automatic report(input string what, input deq_result_t exp, input deq_result_t got);
    failures++;
    if (failures <= 10)
      $display({"%0t: %s: expected data %h count %0d status %0d,",
                " got data %h count %0d status %0d"},
               $realtime, what, exp.read_data, exp.count, exp.status,
               got.read_data, got.count, got.status);
  endtask

  initial begin
    failures    = 0;
    outstanding = 0;
    head        = '0;
    fill        = '0;
  end

  always @(posedge clk) begin
    deq_result_t exp;
    deq_result_t got;
    if (rst) begin
      head = '0;
      fill = '0;
      awaited_results.delete();
    end else begin
      if (req.valid && req.ready)
        awaited_results.insert(awaited_results.size(),
                               apply_request(req.opcode, req.value, req.position));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.read_data, rsp.count, rsp.status};
        if (awaited_results.size() == 0) begin
          report("unexpected item", '0, got);
        end else begin
          exp = awaited_results[0];
          awaited_results.delete(0);
          if (got !== exp) report("mismatch", exp, got);
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

@@ tb/double_ended_queue_tb.sv @@
// Testbench top for the double-ended queue: clock, reset, stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int RANDOM_ITEMS = 950;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst;

  deq_req_if req();
  deq_rsp_if rsp();

  int failures;
  int outstanding;
  int phase;
  logic hold_go;
  int tx_idle_pct;
  int hold_left;
  bit hold_done;
  int stall_cycles;

  double_ended_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  double_ended_queue_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic offer(input logic [deq_pkg::OPCODE_W-1:0] op,
                       input logic [deq_pkg::VALUE_W-1:0] val,
                       input logic [deq_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.opcode   <= op;
    req.value    <= val;
    req.position <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [deq_pkg::OPCODE_W-1:0] pick_op(input int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: begin  // filling
        if (r < 75)
          return ($urandom_range(1) != 0) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        if (r < 90)
          return deq_pkg::OPCODE_W'(deq_pkg::OP_READ_FRONT + $urandom_range(2));
        return ($urandom_range(1) != 0) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
      end
      1: begin  // draining
        if (r < 60)
          return ($urandom_range(1) != 0) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
        if (r < 85)
          return deq_pkg::OPCODE_W'(deq_pkg::OP_READ_FRONT + $urandom_range(2));
        return ($urandom_range(1) != 0) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
      end
      2: begin
        if (r < 2) return deq_pkg::OP_CLEAR;
        return deq_pkg::OPCODE_W'($urandom_range(6));
      end
      default: return deq_pkg::OPCODE_W'($urandom_range(7));
    endcase
  endfunction

  // Receiver: random stalls per phase, plus one long hold-off at the start of the last phase.
  initial begin
    int rx_idle_pct;
    rsp.ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 37 : 0;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("double_ended_queue_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int seg_left;
    int next_phase;
    logic [deq_pkg::OPCODE_W-1:0] op;
    logic [deq_pkg::POS_W-1:0] pos;
    rst          <= 1'b1;
    req.valid    <= 1'b0;
    req.opcode   <= deq_pkg::OP_CLEAR;
    req.value    <= '0;
    req.position <= '0;
    phase        <= 0;
    hold_go      <= 1'b0;
    tx_idle_pct  = 37;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, both ends, data extremes, index limits, clear and wrap
    offer(deq_pkg::OP_POP_BACK,   '0, '0);
    offer(deq_pkg::OP_POP_FRONT,  '0, '0);
    offer(deq_pkg::OP_READ_FRONT, '0, '0);
    offer(deq_pkg::OP_READ_BACK,  '0, '0);
    offer(deq_pkg::OP_READ_INDEX, '0, '0);
    offer(deq_pkg::OP_PUSH_BACK,  32'h0000_0000, '0);
    offer(deq_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF, '0);
    offer(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_A5A5, '0);
    offer(deq_pkg::OP_READ_FRONT, '0, '0);
    offer(deq_pkg::OP_READ_BACK,  '0, '0);
    offer(deq_pkg::OP_READ_INDEX, '0, 6'd1);
    offer(deq_pkg::OP_READ_INDEX, '0, 6'd2);
    offer(deq_pkg::OP_READ_INDEX, '0, 6'd3);
    offer(deq_pkg::OP_READ_INDEX, '0, 6'd63);
    offer(deq_pkg::OP_POP_FRONT,  '0, '0);
    offer(deq_pkg::OP_POP_BACK,   '0, '0);
    offer(deq_pkg::OP_CLEAR,      '0, '0);
    offer(deq_pkg::OP_READ_FRONT, '0, '0);
    offer(deq_pkg::OP_PUSH_FRONT, 32'h8000_0001, '0);
    offer(deq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFE, '0);
    offer(deq_pkg::OP_READ_INDEX, '0, 6'd1);
    offer(deq_pkg::OP_READ_BACK,  '0, '0);
    offer(deq_pkg::OP_CLEAR,      '0, '0);

    seg_left = 0;
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      next_phase = n * 3 / RANDOM_ITEMS;
      if (next_phase != phase) begin
        phase <= next_phase;
        if (next_phase == 2) hold_go <= 1'b1;
      end
      tx_idle_pct = (next_phase == 0) ? 37 : (next_phase == 1) ? 84 : 0;
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 90);
        case ($urandom_range(9))
          0, 1, 2, 3: mode = 0;
          4, 5, 6:    mode = 1;
          7, 8:       mode = 2;
          default:    mode = 3;
        endcase
      end
      seg_left--;
      op  = pick_op(mode);
      pos = ($urandom_range(1) != 0) ? deq_pkg::POS_W'($urandom_range(63))
                                     : deq_pkg::POS_W'($urandom_range(15));
      offer(op, $urandom, pos);
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("double_ended_queue_tb: done, clean");
    else
      $display("double_ended_queue_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
sv/deq_pkg.sv
sv/deq_if.sv
sv/double_ended_queue.sv
tb/double_ended_queue_checker.sv
tb/double_ended_queue_tb.sv
